>>> design/pied_pkg.sv
// ----------------------------------------------------------------------------
// pied_pkg - shared definitions for the priority input event dispatcher
// Register indexes, trigger and class codes, controller states, and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package pied_pkg;

    localparam int CHANNELS   = 16;
    localparam int LEVEL_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int CLASS_W    = 2;
    localparam int MODE_W     = 3;
    localparam int MODES_W    = MODE_W * LEVEL_W;
    localparam int CLASSES_W  = CLASS_W * LEVEL_W;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_CLASSES = 2'd3;

    localparam logic [MODE_W-1:0] MODE_RISING  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FALLING = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHANGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HIGH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOW     = 3'd4;

    localparam logic [CLASS_W-1:0] PRIO_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] PRIO_LOW    = 2'd1;
    localparam logic [CLASS_W-1:0] PRIO_MEDIUM = 2'd2;
    localparam logic [CLASS_W-1:0] PRIO_HIGH   = 2'd3;

    localparam logic [MODES_W-1:0]   MODES_RESET   = 48'h4924_9249_2492;
    localparam logic [CLASSES_W-1:0] CLASSES_RESET = 32'hAAAA_AAAA;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } pied_state_t;

    typedef struct packed {
        logic cap;
        logic emit;
    } pied_cmd_t;

    typedef struct packed {
        logic global_en;
        logic pending;
        logic last_pick;
        logic out_free;
    } pied_sts_t;

    function automatic logic [INDEX_W-1:0] lowest_set(input logic [LEVEL_W-1:0] v);
        logic [INDEX_W-1:0] idx;
        idx = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = INDEX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> design/pied_ctrl.sv
// ----------------------------------------------------------------------------
// pied_ctrl - sample controller
// Accepts a sample when idle, then steps the datapath through the pending
// events, one beat per cycle while the output slot is free.
// ----------------------------------------------------------------------------
module pied_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  pied_pkg::pied_sts_t sts,
    output pied_pkg::pied_cmd_t cmd
);

    pied_pkg::pied_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pied_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            pied_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                // a disabled sample is taken and dropped
                if (s_axis_tvalid && sts.global_en) begin
                    cmd.cap    = 1'b1;
                    state_next = pied_pkg::ST_SCAN;
                end
            end
            pied_pkg::ST_SCAN: begin
                if (!sts.pending) begin
                    state_next = pied_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_pick) begin
                        state_next = pied_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = pied_pkg::ST_IDLE;
        endcase
    end

    a_cap_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap |=> !s_axis_tready)
        else $error("input still ready after capture");

    a_emit_only_scanning: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> state_reg == pied_pkg::ST_SCAN && sts.pending)
        else $error("emit outside of scan");

endmodule

>>> design/pied_datapath.sv
// ----------------------------------------------------------------------------
// pied_datapath - trigger evaluation, class masks and output register
// Evaluates all channels on capture, holds per-class hit masks, and picks
// the next event by class then ascending index into the output register.
// ----------------------------------------------------------------------------
module pied_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pied_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [pied_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic [pied_pkg::LEVEL_W-1:0]        s_levels,
    input  pied_pkg::pied_cmd_t                 cmd,
    output pied_pkg::pied_sts_t                 sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pied_pkg::INDEX_W-1:0]        m_index,
    output logic                                m_level,
    output logic [pied_pkg::CLASS_W-1:0]        m_class,
    output logic                                m_last
);

    logic                              global_en_reg;
    logic [pied_pkg::LEVEL_W-1:0]      chan_en_reg;
    logic [pied_pkg::MODES_W-1:0]      modes_reg;
    logic [pied_pkg::CLASSES_W-1:0]    classes_reg;
    logic [pied_pkg::LEVEL_W-1:0]      prev_reg;
    logic [pied_pkg::LEVEL_W-1:0]      cur_reg;
    logic [pied_pkg::LEVEL_W-1:0]      hi_reg, med_reg, lo_reg;
    logic [pied_pkg::LEVEL_W-1:0]      hi_next, med_next, lo_next;
    logic [pied_pkg::LEVEL_W-1:0]      hit;
    logic [pied_pkg::LEVEL_W-1:0]      sel_mask, onehot, all_mask;
    logic [pied_pkg::CLASS_W-1:0]      sel_class;
    logic [pied_pkg::INDEX_W-1:0]      pick_idx;
    logic                              out_valid_reg;
    logic [pied_pkg::INDEX_W-1:0]      out_index_reg;
    logic                              out_level_reg;
    logic [pied_pkg::CLASS_W-1:0]      out_class_reg;
    logic                              out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_en_reg <= 1'b0;
            chan_en_reg   <= '0;
            modes_reg     <= pied_pkg::MODES_RESET;
            classes_reg   <= pied_pkg::CLASSES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                pied_pkg::REG_GLOBAL_ENABLE:    global_en_reg <= cfg_wr_data[0];
                pied_pkg::REG_CHANNEL_ENABLE:   chan_en_reg <= cfg_wr_data[pied_pkg::LEVEL_W-1:0];
                pied_pkg::REG_TRIGGER_MODES:    modes_reg <= cfg_wr_data[pied_pkg::MODES_W-1:0];
                pied_pkg::REG_PRIORITY_CLASSES:
                    classes_reg <= cfg_wr_data[pied_pkg::CLASSES_W-1:0];
                default: ;
            endcase
        end
    end

    // trigger check for every handled channel, in parallel
    always_comb begin
        logic [pied_pkg::MODE_W-1:0] mode;
        logic p, c;
        hit = '0;
        for (int i = 0; i < pied_pkg::CHANNELS; i++) begin
            mode = modes_reg[pied_pkg::MODE_W*i +: pied_pkg::MODE_W];
            p    = prev_reg[i];
            c    = s_levels[i];
            unique case (mode)
                pied_pkg::MODE_RISING:  hit[i] = !p && c;
                pied_pkg::MODE_FALLING: hit[i] = p && !c;
                pied_pkg::MODE_CHANGE:  hit[i] = p != c;
                pied_pkg::MODE_HIGH:    hit[i] = c;
                pied_pkg::MODE_LOW:     hit[i] = !c;
                default:                hit[i] = 1'b0;
            endcase
            hit[i] = hit[i] && chan_en_reg[i];
        end
    end

    // pick: highest non-empty class, lowest index within it
    always_comb begin
        priority if (hi_reg != '0) begin
            sel_mask  = hi_reg;
            sel_class = pied_pkg::PRIO_HIGH;
        end else if (med_reg != '0) begin
            sel_mask  = med_reg;
            sel_class = pied_pkg::PRIO_MEDIUM;
        end else begin
            sel_mask  = lo_reg;
            sel_class = pied_pkg::PRIO_LOW;
        end
        pick_idx = pied_pkg::lowest_set(sel_mask);
        onehot   = pied_pkg::LEVEL_W'(1) << pick_idx;
        all_mask = hi_reg | med_reg | lo_reg;
    end

    always_comb begin
        hi_next  = hi_reg;
        med_next = med_reg;
        lo_next  = lo_reg;
        if (cmd.cap) begin
            for (int i = 0; i < pied_pkg::LEVEL_W; i++) begin
                hi_next[i]  = hit[i] &&
                    classes_reg[pied_pkg::CLASS_W*i +: pied_pkg::CLASS_W] == pied_pkg::PRIO_HIGH;
                med_next[i] = hit[i] &&
                    classes_reg[pied_pkg::CLASS_W*i +: pied_pkg::CLASS_W] == pied_pkg::PRIO_MEDIUM;
                lo_next[i]  = hit[i] &&
                    classes_reg[pied_pkg::CLASS_W*i +: pied_pkg::CLASS_W] == pied_pkg::PRIO_LOW;
            end
        end else if (cmd.emit) begin
            // classes are disjoint, so clearing the bit everywhere is safe
            hi_next  = hi_reg & ~onehot;
            med_next = med_reg & ~onehot;
            lo_next  = lo_reg & ~onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg   <= '0;
            med_reg  <= '0;
            lo_reg   <= '0;
            prev_reg <= '0;
        end else begin
            hi_reg  <= hi_next;
            med_reg <= med_next;
            lo_reg  <= lo_next;
            if (cmd.cap) begin
                prev_reg <= s_levels;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            cur_reg <= s_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_index_reg <= pick_idx;
            out_level_reg <= cur_reg[pick_idx];
            out_class_reg <= sel_class;
            out_last_reg  <= (all_mask & ~onehot) == '0;
        end
    end

    assign sts.global_en = global_en_reg;
    assign sts.pending   = all_mask != '0;
    assign sts.last_pick = (all_mask & ~onehot) == '0;
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_index = out_index_reg;
    assign m_level = out_level_reg;
    assign m_class = out_class_reg;
    assign m_last  = out_last_reg;

    a_emit_has_event: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.pending && sts.out_free)
        else $error("emit without a pending event or free slot");

    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.last_pick) |=> !sts.pending && m_valid && m_last)
        else $error("events left after the last beat");

endmodule

>>> design/priority_input_event_dispatcher.sv
// ----------------------------------------------------------------------------
// priority_input_event_dispatcher - edge/level event dispatcher, 16 inputs
// Channel     Dir  Beat contents
// s_axis      in   tdata[15:0] input_levels
// m_axis      out  tdata[3:0] channel_index, tdata[4] level, tuser[1:0]
//                  priority_class, tlast last
// cfg_wr      in   index 0 enable, 1 channel mask, 2 modes, 3 classes
//
// A sample is captured first, then the event pick loop reports one event per
// cycle while the output register is free, and returns to idle once none are left.
// A sample with the global enable off is taken and dropped.
// Output stalls hold the pick loop; the next sample is taken while the last
// beat still waits in the output register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module priority_input_event_dispatcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pied_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [pied_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // [15:0] input_levels
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [3:0] channel_index, [4] level
    output logic [1:0]                       m_axis_tuser,  // [1:0] priority_class
    output logic                             m_axis_tlast
);

    pied_pkg::pied_cmd_t             cmd;
    pied_pkg::pied_sts_t             sts;
    logic [pied_pkg::INDEX_W-1:0]    m_index;
    logic                            m_level;

    pied_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    pied_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_levels     (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_index      (m_index),
        .m_level      (m_level),
        .m_class      (m_axis_tuser),
        .m_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, m_level, m_index};

endmodule
